// ----- hw/rtl/ms_tick_scheduler_rtc_macros.svh -----
// ----------------------------------------------------------------------------
// ms_tick_scheduler_rtc_macros.svh
// Assertion macros for the millisecond tick scheduler; clock clk, reset rst.
// ----------------------------------------------------------------------------
`ifndef MS_TICK_SCHEDULER_RTC_MACROS_SVH
`define MS_TICK_SCHEDULER_RTC_MACROS_SVH

`ifndef ASSERT_OFF

// Condition holds at every clock edge out of reset.
`define MTSR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence holds in the cycle after the antecedent.
`define MTSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MTSR_ASSERT_ALWAYS(lbl, cond, msg)
`define MTSR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/mtsr_pkg.sv -----
// ----------------------------------------------------------------------------
// mtsr_pkg
// Types and constants shared by the tick scheduler modules.
// ----------------------------------------------------------------------------
package mtsr_pkg;

  localparam int SUB_W   = 10;
  localparam int HOURS_W = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int FLAGS_W = 3;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;

  localparam logic [MIN_W-1:0]   MINUTES_PER_HOUR   = 6'd60;
  localparam logic [SEC_W-1:0]   SECONDS_PER_MINUTE = 6'd60;
  localparam logic [HOURS_W-1:0] HOURS_PER_DAY      = 5'd24;

  // Residue counters that track the sub-second count modulo each task period
  localparam logic [2:0] PERIOD_5_LAST   = 3'd4;
  localparam logic [5:0] PERIOD_50_LAST  = 6'd49;
  localparam logic [8:0] PERIOD_500_LAST = 9'd499;

  // Flag bit positions
  localparam int FLAG_5MS   = 0;
  localparam int FLAG_50MS  = 1;
  localparam int FLAG_500MS = 2;

  typedef struct packed {
    logic               tick;
    logic [FLAGS_W-1:0] ack_mask;
    logic               set_time;
    logic [HOURS_W-1:0] new_hours;
    logic [MIN_W-1:0]   new_minutes;
    logic [SEC_W-1:0]   new_seconds;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        ms_count;
    logic [FLAGS_W-1:0] pending;
    logic [HOURS_W-1:0] hours_now;
    logic [MIN_W-1:0]   minutes_now;
    logic [SEC_W-1:0]   seconds_now;
  } result_t;

endpackage

// ----- hw/rtl/mtsr_in_stage.sv -----
// ----------------------------------------------------------------------------
// mtsr_in_stage
// Input register: captures one word per cycle while the core keeps taking them, holds it until the core takes it.
// ----------------------------------------------------------------------------
module mtsr_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mtsr_pkg::in_item_t in_item,
  input  logic               take,
  output logic               item_valid,
  output mtsr_pkg::in_item_t item
);
  import mtsr_pkg::*;

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ----- hw/rtl/mtsr_core.sv -----
// ----------------------------------------------------------------------------
// mtsr_core
// Clock state, task flags and the single-pass update for one input word.
// ----------------------------------------------------------------------------
`include "ms_tick_scheduler_rtc_macros.svh"

module mtsr_core #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  mtsr_pkg::in_item_t item,
  output mtsr_pkg::result_t  result
);
  import mtsr_pkg::*;

  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(TICKS_PER_SECOND - 1);

  logic [31:0]        ms_total;
  logic [SUB_W-1:0]   sub_second;
  logic [2:0]         res_5;
  logic [5:0]         res_50;
  logic [8:0]         res_500;
  logic [HOURS_W-1:0] hours_reg;
  logic [MIN_W-1:0]   minutes_reg;
  logic [SEC_W-1:0]   seconds_reg;
  logic [FLAGS_W-1:0] task_flags;

  logic [31:0]        ms_total_next;
  logic [SUB_W-1:0]   sub_second_next;
  logic [2:0]         res_5_next;
  logic [5:0]         res_50_next;
  logic [8:0]         res_500_next;
  logic [HOURS_W-1:0] hours_next;
  logic [MIN_W-1:0]   minutes_next;
  logic [SEC_W-1:0]   seconds_next;
  logic [FLAGS_W-1:0] flags_raised;

  logic               sub_wrap;
  logic [HOURS_W-1:0] hours_ld;
  logic [MIN_W-1:0]   minutes_ld;
  logic [SEC_W-1:0]   seconds_ld;
  logic [SEC_W-1:0]   sec_a;
  logic [MIN_W-1:0]   min_a;
  logic [HOURS_W-1:0] hour_a;

  always_comb begin
    hours_ld   = item.set_time ? item.new_hours   : hours_reg;
    minutes_ld = item.set_time ? item.new_minutes : minutes_reg;
    seconds_ld = item.set_time ? item.new_seconds : seconds_reg;

    sub_wrap = (sub_second == SUB_LAST);

    // Cascade seconds -> minutes -> hours; out-of-range values fold to zero
    sec_a  = sub_wrap ? seconds_ld + SEC_W'(1) : seconds_ld;
    min_a  = minutes_ld;
    hour_a = hours_ld;
    if (sec_a >= SECONDS_PER_MINUTE) begin
      sec_a = '0;
      min_a = minutes_ld + MIN_W'(1);
    end
    if (min_a >= MINUTES_PER_HOUR) begin
      min_a  = '0;
      hour_a = hours_ld + HOURS_W'(1);
    end
    if (hour_a >= HOURS_PER_DAY) begin
      hour_a = '0;
    end

    if (item.tick) begin
      ms_total_next   = ms_total + 32'd1;
      sub_second_next = sub_wrap ? '0 : sub_second + SUB_W'(1);
      res_5_next      = (sub_wrap || res_5 == PERIOD_5_LAST) ? '0 : res_5 + 3'd1;
      res_50_next     = (sub_wrap || res_50 == PERIOD_50_LAST) ? '0 : res_50 + 6'd1;
      res_500_next    = (sub_wrap || res_500 == PERIOD_500_LAST) ? '0 : res_500 + 9'd1;
      flags_raised    = task_flags;
      flags_raised[FLAG_5MS]   = task_flags[FLAG_5MS]   | (res_5 == '0);
      flags_raised[FLAG_50MS]  = task_flags[FLAG_50MS]  | (res_50 == '0);
      flags_raised[FLAG_500MS] = task_flags[FLAG_500MS] | (res_500 == '0);
      hours_next      = hour_a;
      minutes_next    = min_a;
      seconds_next    = sec_a;
    end else begin
      ms_total_next   = ms_total;
      sub_second_next = sub_second;
      res_5_next      = res_5;
      res_50_next     = res_50;
      res_500_next    = res_500;
      flags_raised    = task_flags;
      hours_next      = hours_ld;
      minutes_next    = minutes_ld;
      seconds_next    = seconds_ld;
    end

    result.ms_count    = ms_total_next;
    result.pending     = flags_raised;
    result.hours_now   = hours_next;
    result.minutes_now = minutes_next;
    result.seconds_now = seconds_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_total    <= '0;
      sub_second  <= '0;
      res_5       <= '0;
      res_50      <= '0;
      res_500     <= '0;
      hours_reg   <= '0;
      minutes_reg <= '0;
      seconds_reg <= '0;
      task_flags  <= '0;
    end else if (step) begin
      ms_total    <= ms_total_next;
      sub_second  <= sub_second_next;
      res_5       <= res_5_next;
      res_50      <= res_50_next;
      res_500     <= res_500_next;
      hours_reg   <= hours_next;
      minutes_reg <= minutes_next;
      seconds_reg <= seconds_next;
      // Clear acknowledged flags after they have been reported
      task_flags  <= flags_raised & ~item.ack_mask;
    end
  end

  `MTSR_ASSERT_ALWAYS(a_sub_in_range, sub_second <= SUB_LAST, "sub-second count out of range")
  `MTSR_ASSERT_ALWAYS(a_res_aligned, (sub_second != '0) || (res_5 == '0 && res_50 == '0 && res_500 == '0), "residue counters not aligned at second start")
  `MTSR_ASSERT_NEXT(a_ms_advance, step && item.tick, ms_total == $past(ms_total) + 32'd1, "ms count did not advance on tick")
  `MTSR_ASSERT_NEXT(a_ack_clears, step && item.ack_mask[FLAG_5MS], !task_flags[FLAG_5MS], "acknowledged 5 ms flag still set")

endmodule

// ----- hw/rtl/mtsr_out_stage.sv -----
// ----------------------------------------------------------------------------
// mtsr_out_stage
// Result register: holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module mtsr_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  mtsr_pkg::result_t result_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              can_load,
  output mtsr_pkg::result_t result_q
);
  import mtsr_pkg::*;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_q <= result_in;
    end
  end

endmodule

// ----- hw/rtl/ms_tick_scheduler_rtc.sv -----
// ----------------------------------------------------------------------------
// ms_tick_scheduler_rtc
// Millisecond tick scheduler with 5/50/500 ms task flags and time of day.
// ----------------------------------------------------------------------------
// Takes one input word per clock and returns one result word for each. A word
// sits in the input register while a single pass of counter logic computes
// its state update; the result register loads when the word leaves the input
// register, so m_tvalid rises once the result register holds the result, which
// can be taken from there. That single pass sets the sustained rate at one
// word per cycle while the result side keeps up; a stalled result register
// holds the input register and drops s_tready.
// Task flags read as raised before the word's ack_mask clears them.
module ms_tick_scheduler_rtc #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // tick[0], ack_mask[3:1], new_hours[8:4], new_minutes[14:9], new_seconds[20:15]
  input  logic [mtsr_pkg::IN_TDATA_W-1:0] s_tdata,
  // set_time[0]
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // ms_count[31:0], pending_5ms[32], pending_50ms[33], pending_500ms[34],
  // hours_now[39:35], minutes_now[45:40], seconds_now[51:46]
  output logic [mtsr_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import mtsr_pkg::*;

  in_item_t in_item;
  in_item_t item;
  result_t  result;
  result_t  result_q;
  logic     item_valid;
  logic     can_load;
  logic     step;

  always_comb begin
    in_item.tick        = s_tdata[0];
    in_item.ack_mask    = s_tdata[3:1];
    in_item.new_hours   = s_tdata[8:4];
    in_item.new_minutes = s_tdata[14:9];
    in_item.new_seconds = s_tdata[20:15];
    in_item.set_time    = s_tuser;
  end

  assign step = item_valid && can_load;

  mtsr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .take       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  mtsr_core #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .result (result)
  );

  mtsr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .result_in (result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .can_load  (can_load),
    .result_q  (result_q)
  );

  assign m_tdata = {4'b0, result_q.seconds_now, result_q.minutes_now, result_q.hours_now,
                    result_q.pending[FLAG_500MS], result_q.pending[FLAG_50MS],
                    result_q.pending[FLAG_5MS], result_q.ms_count};

endmodule
